@@ hw/rtl/cpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpfc_pkg: shared types and functions of the CRC-16 packet framer/checker
// Holds the request payload types, the result group descriptor and the
// byte-wide CRC-16 update (polynomial 0x1021, MSB first).
// ----------------------------------------------------------------------------
package cpfc_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_MSB   = 16'h8000;
    localparam logic [1:0]  HOLD_FULL = 2'd3;   // two held, at least one folded

    // Number of results that one request causes.
    localparam logic [1:0] GRP_NONE  = 2'd0;
    localparam logic [1:0] GRP_ONE   = 2'd1;
    localparam logic [1:0] GRP_THREE = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        is_verdict;
        logic        crc_ok;
        logic [15:0] crc_value;
    } t_out_item;

    // Result group produced by one request, handed from engine to emitter.
    typedef struct packed {
        logic        load;
        logic [1:0]  count;
        logic [7:0]  data_byte;
        logic [15:0] crc;
        logic        is_verdict;
        logic        crc_ok;
    } t_grp;

    // Fold one byte into the CRC, one bit per step.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/cpfc_if.sv @@
// ----------------------------------------------------------------------------
// cpfc_in_if / cpfc_out_if: valid/ready channels of the packet framer/checker
// One interface carries input byte requests, the other result requests.
// ----------------------------------------------------------------------------
interface cpfc_in_if;
    logic              valid;
    logic              ready;
    cpfc_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cpfc_out_if;
    logic               valid;
    logic               ready;
    cpfc_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ hw/rtl/cpfc_engine.sv @@
// ----------------------------------------------------------------------------
// cpfc_engine: CRC state and two-byte hold of the framer/checker
// Updates the running CRC and the hold on each accepted request and builds
// the group of results that the request causes.
// ----------------------------------------------------------------------------
module cpfc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cpfc_in_if.sink             i_in,
    input  logic                i_slot_free,
    output cpfc_pkg::t_grp      o_grp
);

    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_older,  n_older;
    logic [7:0]  r_newer,  n_newer;
    logic [1:0]  r_hcount, n_hcount;

    logic        accept;
    logic [15:0] crc_base;
    logic [1:0]  hcount_base;
    cpfc_pkg::t_grp grp;

    assign i_in.ready = i_slot_free;
    assign accept     = i_in.valid && i_slot_free;

    always_comb begin
        crc_base    = i_in.item.first ? 16'h0000 : r_crc;
        hcount_base = i_in.item.first ? 2'd0 : r_hcount;
        n_crc       = r_crc;
        n_older     = r_older;
        n_newer     = r_newer;
        n_hcount    = r_hcount;
        grp         = '0;
        if (!i_in.item.func) begin
            // Send: the byte goes out and folds into the CRC; the hold stays.
            n_crc          = cpfc_pkg::crc_fold(crc_base, i_in.item.data_byte);
            grp.count      = i_in.item.last ? cpfc_pkg::GRP_THREE : cpfc_pkg::GRP_ONE;
            grp.data_byte  = i_in.item.data_byte;
        end else begin
            // Check: the oldest held byte folds once two are held.
            n_crc    = (hcount_base >= 2'd2) ? cpfc_pkg::crc_fold(crc_base, r_older)
                                             : crc_base;
            n_older  = r_newer;
            n_newer  = i_in.item.data_byte;
            n_hcount = (hcount_base == cpfc_pkg::HOLD_FULL) ? cpfc_pkg::HOLD_FULL
                                                            : hcount_base + 2'd1;
            grp.count      = i_in.item.last ? cpfc_pkg::GRP_ONE : cpfc_pkg::GRP_NONE;
            grp.is_verdict = 1'b1;
            grp.crc_ok     = (n_hcount == cpfc_pkg::HOLD_FULL)
                          && ({r_newer, i_in.item.data_byte} == n_crc);
        end
        grp.crc  = n_crc;
        grp.load = accept && (grp.count != cpfc_pkg::GRP_NONE);
    end

    assign o_grp = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= '0;
            r_older  <= '0;
            r_newer  <= '0;
            r_hcount <= '0;
        end else if (accept) begin
            r_crc    <= n_crc;
            r_older  <= n_older;
            r_newer  <= n_newer;
            r_hcount <= n_hcount;
        end
    end

endmodule

@@ hw/rtl/cpfc_emitter.sv @@
// ----------------------------------------------------------------------------
// cpfc_emitter: result register of the framer/checker
// Holds one result group and hands its results out one per request.
// ----------------------------------------------------------------------------
module cpfc_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpfc_pkg::t_grp i_grp,
    output logic           o_slot_free,
    cpfc_out_if.source     o_out
);

    logic           r_busy, n_busy;
    logic [1:0]     r_idx,  n_idx;
    cpfc_pkg::t_grp r_grp;

    logic take;
    logic done;

    assign take        = r_busy && o_out.ready;
    assign done        = take && (r_idx == r_grp.count - 2'd1);
    assign o_slot_free = !r_busy || done;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_grp.load) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_idx  = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp.load) begin
            r_grp <= i_grp;
        end
    end

    always_comb begin
        o_out.valid           = r_busy;
        o_out.item.out_last   = (r_idx == r_grp.count - 2'd1);
        o_out.item.is_verdict = r_grp.is_verdict;
        o_out.item.crc_ok     = r_grp.crc_ok;
        o_out.item.crc_value  = r_grp.crc;
        case (r_idx)
            2'd0:    o_out.item.out_byte = r_grp.is_verdict ? 8'h00 : r_grp.data_byte;
            2'd1:    o_out.item.out_byte = r_grp.crc[15:8];
            2'd2:    o_out.item.out_byte = r_grp.crc[7:0];
            default: o_out.item.out_byte = 8'h00;
        endcase
    end

endmodule

@@ hw/rtl/crc16_packet_framer_checker.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_framer_checker: CRC-16 packet framer and checker
// Sends frames with an appended CRC-16 (poly 0x1021, init 0) or checks
// received frames against their trailing two CRC bytes.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on i_in, one request per byte, with func choosing send (0) or
// check (1) and first/last marking the frame edges. Results leave on o_out.
// In send mode each byte comes back as one result; the last byte of a frame
// is followed by the CRC high and low bytes, out_last marking the third.
// In check mode the two newest bytes are held back from the CRC, and only
// the last byte gives a result: a verdict with crc_ok set when the held
// bytes, read big-endian, equal the CRC of all earlier bytes. Frames shorter
// than three bytes always fail.
// A result is valid in the cycle after its request.
// Throughput is one request per cycle while the receiver takes every result;
// a send-mode last byte blocks new requests until its third result is taken.
// Throughput is set by the single result register, which is refilled in the
// same cycle that its final result is taken.
// When the receiver stalls, the result register holds and i_in.ready drops.
// Reset clears the CRC and the hold and empties the result register; nothing
// is output.
// ----------------------------------------------------------------------------
module crc16_packet_framer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpfc_in_if.sink     i_in,
    cpfc_out_if.source  o_out
);

    cpfc_pkg::t_grp grp;
    logic           slot_free;

    // The engine owns the CRC and hold state and accepts a request whenever
    // the result register is free or is being emptied in this cycle.
    cpfc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (slot_free),
        .o_grp       (grp)
    );

    // The emitter keeps the result group and walks through its results.
    cpfc_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp),
        .o_slot_free (slot_free),
        .o_out       (o_out)
    );

    // A verdict is always the single, final result of its request.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.item.is_verdict) |->
            (o_out.item.out_last && (o_out.item.out_byte == 8'h00)))
        else $error("verdict result is not a lone final result");

    // No request is taken while a result is stuck at the output.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("request accepted while output stalled");

    // A send-mode last byte starts a three-result group.
    a_send_last_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.item.func && i_in.item.last) |=>
            (o_out.valid && !o_out.item.out_last && !o_out.item.is_verdict))
        else $error("send frame end did not start CRC append");

    // A result of a check-mode middle byte never appears.
    a_check_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.item.func && !i_in.item.last) |=>
            !o_out.valid)
        else $error("check-mode middle byte produced a result");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CRC-16 packet framer/checker
// Drives send and check frames, well formed and broken, through the request
// channel. A scoreboard tracks its own CRC and hold state, predicts every
// result, and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------

localparam logic FUNC_SEND  = 1'b0;
localparam logic FUNC_CHECK = 1'b1;

typedef logic [7:0] t_byte_q[$];

// Serial form of the XMODEM update: one data bit per step, MSB first.
function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? cpfc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
endfunction

// Tracks the CRC and the two-byte hold of the block and keeps the results
// that are still owed, oldest first.
class crc_frame_tracker;
    logic [15:0]         crc_acc;
    logic [7:0]          hold_old;
    logic [7:0]          hold_new;
    logic [1:0]          hold_cnt;
    cpfc_pkg::t_out_item pending_results[$];
    int unsigned         mismatches;

    function new();
        crc_acc    = '0;
        hold_old   = '0;
        hold_new   = '0;
        hold_cnt   = '0;
        mismatches = 0;
    endfunction

    function void owe_result(logic [7:0] b, logic olast, logic verdict, logic ok);
        cpfc_pkg::t_out_item r;
        r.out_byte   = b;
        r.out_last   = olast;
        r.is_verdict = verdict;
        r.crc_ok     = ok;
        r.crc_value  = crc_acc;
        pending_results.push_back(r);
    endfunction

    // Called once per accepted request.
    function void note_byte(cpfc_pkg::t_in_item req);
        if (req.first) begin
            crc_acc = '0;
        end
        if (req.func == FUNC_SEND) begin
            crc_acc = fold_byte(crc_acc, req.data_byte);
            owe_result(req.data_byte, !req.last, 1'b0, 1'b0);
            if (req.last) begin
                owe_result(crc_acc[15:8], 1'b0, 1'b0, 1'b0);
                owe_result(crc_acc[7:0], 1'b1, 1'b0, 1'b0);
            end
        end else begin
            if (req.first) begin
                hold_cnt = '0;
            end
            // The older held byte drops into the CRC once two are held.
            if (hold_cnt >= 2'd2) begin
                crc_acc = fold_byte(crc_acc, hold_old);
            end
            hold_old = hold_new;
            hold_new = req.data_byte;
            if (hold_cnt != cpfc_pkg::HOLD_FULL) begin
                hold_cnt = hold_cnt + 2'd1;
            end
            if (req.last) begin
                owe_result(8'h00, 1'b1, 1'b1,
                           (hold_cnt == cpfc_pkg::HOLD_FULL)
                           && ({hold_old, hold_new} == crc_acc));
            end
        end
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_result(cpfc_pkg::t_out_item got);
        cpfc_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            report($sformatf("result with nothing expected: byte %02h verdict %0b crc %04h",
                             got.out_byte, got.is_verdict, got.crc_value));
            return;
        end
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
        if (got.out_last !== want.out_last)
            report($sformatf("out_last %0b, expected %0b", got.out_last, want.out_last));
        if (got.is_verdict !== want.is_verdict)
            report($sformatf("is_verdict %0b, expected %0b", got.is_verdict, want.is_verdict));
        if (got.crc_ok !== want.crc_ok)
            report($sformatf("crc_ok %0b, expected %0b", got.crc_ok, want.crc_ok));
        if (got.crc_value !== want.crc_value)
            report($sformatf("crc_value %04h, expected %04h", got.crc_value, want.crc_value));
    endtask
endclass

module testbench;

    // Cycles without any accepted request on either channel before the run
    // is declared hung. A correct run never comes close: the longest quiet
    // spell is a short random stall or the final settle.
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic calm;            // when set, neither side idles
    int   items_sent;
    int   quiet_cycles;

    crc_frame_tracker tracker;

    cpfc_in_if  req_if();
    cpfc_out_if res_if();

    crc16_packet_framer_checker DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Each side pauses at random with a chance of roughly six in a hundred on each draw,
    // except during the calm stretch in the middle of the random part.
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    // The result receiver stalls at random, independent of the sender.
    always @(posedge clk) begin
        res_if.ready <= !take_break();
    end

    // Every accepted result is checked against the oldest prediction. The
    // values are sampled at the edge itself, before any update lands.
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            tracker.check_result(res_if.item);
        end
    end

    // Hang detection: count cycles in which neither channel moves a request.
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it. The task is
    // entered at a clock edge and leaves at the edge of acceptance with valid
    // still high, so the next call either lowers it for a break or replaces
    // the payload; valid never gets two assignments in one step.
    task automatic drive_request(input cpfc_pkg::t_in_item req);
        while (take_break()) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.item  <= req;
        @(posedge clk);
        while (!req_if.ready) begin
            @(posedge clk);
        end
        tracker.note_byte(req);
        items_sent++;
    endtask

    // One frame: first on the opening byte (when asked), last on the final one.
    task automatic drive_frame(input logic mode, input t_byte_q bytes, input logic mark_first);
        cpfc_pkg::t_in_item req;
        foreach (bytes[i]) begin
            req.func      = mode;
            req.data_byte = bytes[i];
            req.first     = mark_first && (i == 0);
            req.last      = (i == bytes.size() - 1);
            drive_request(req);
        end
    endtask

    // Stop sending until every owed result has come back. A clock edge always
    // passes first, so lowering valid never shares a step with raising it again.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (tracker.pending_results.size() != 0);
    endtask

    // A check frame: the body followed by its CRC, high byte first.
    function automatic t_byte_q append_crc(input t_byte_q body);
        t_byte_q     framed;
        logic [15:0] c;
        c = '0;
        foreach (body[i]) begin
            c = fold_byte(c, body[i]);
        end
        framed = body;
        framed.push_back(c[15:8]);
        framed.push_back(c[7:0]);
        return framed;
    endfunction

    function automatic t_byte_q random_bytes(input int n);
        t_byte_q q;
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    initial begin
        cpfc_pkg::t_in_item req;
        t_byte_q  framed;
        int       frames;
        int       kind;
        int       idx;
        logic     mark;

        tracker = new();
        items_sent   = 0;
        calm         <= 1'b0;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.item  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed part ----
        // Single-byte send frames at both ends of the byte range, then a two-byte
        // one: first and last on the same byte give the byte plus both CRC bytes.
        drive_frame(FUNC_SEND, '{8'h00}, 1'b1);
        drive_frame(FUNC_SEND, '{8'hFF}, 1'b1);
        drive_frame(FUNC_SEND, '{8'hFF, 8'h00}, 1'b1);
        // Short check frames of one and two bytes always fail, even when the
        // two bytes happen to equal the (zero) CRC.
        drive_frame(FUNC_CHECK, '{8'hA5}, 1'b1);
        drive_frame(FUNC_CHECK, '{8'h00, 8'h00}, 1'b1);
        // The shortest good check frame, a longer good one, and a corrupted one.
        drive_frame(FUNC_CHECK, append_crc('{8'hFF}), 1'b1);
        drive_frame(FUNC_CHECK, append_crc('{8'h80, 8'h01}), 1'b1);
        framed = append_crc('{8'h5A});
        framed[2] = framed[2] ^ 8'h01;
        drive_frame(FUNC_CHECK, framed, 1'b1);
        // A frame with no first mark carries the CRC over from the last one.
        drive_frame(FUNC_SEND, '{8'h12}, 1'b0);
        // The mode flips byte by byte inside one frame: the send byte folds
        // into the CRC while the check bytes keep using the hold.
        drive_request(cpfc_pkg::t_in_item'{func: FUNC_CHECK, data_byte: 8'h11,
                                           first: 1'b1, last: 1'b0});
        drive_request(cpfc_pkg::t_in_item'{func: FUNC_SEND,  data_byte: 8'h22,
                                           first: 1'b0, last: 1'b0});
        drive_request(cpfc_pkg::t_in_item'{func: FUNC_CHECK, data_byte: 8'h33,
                                           first: 1'b0, last: 1'b0});
        drive_request(cpfc_pkg::t_in_item'{func: FUNC_CHECK, data_byte: 8'h44,
                                           first: 1'b0, last: 1'b1});

        // Let everything settle once before the random part starts.
        drain_results();

        // ---- Random part ----
        // Mostly well-formed frames with random content: send frames, check
        // frames with a correct trailer, and the same with one bit flipped.
        // The rest is short check frames and loose requests with every field
        // random. About one frame in ten omits its first mark.
        frames = 0;
        while (items_sent < 230) begin
            calm <= (frames >= 30) && (frames < 50);
            if (frames == 20) begin
                drain_results();
            end
            kind = $urandom_range(99);
            mark = ($urandom_range(9) != 0);
            if (kind < 40) begin
                drive_frame(FUNC_SEND, random_bytes($urandom_range(8, 1)), mark);
            end else if (kind < 80) begin
                framed = append_crc(random_bytes($urandom_range(6, 1)));
                if ($urandom_range(3) == 0) begin
                    idx = $urandom_range(framed.size() - 1);
                    framed[idx] = framed[idx] ^ 8'(1 << $urandom_range(7));
                end
                drive_frame(FUNC_CHECK, framed, mark);
            end else if (kind < 90) begin
                drive_frame(FUNC_CHECK, random_bytes($urandom_range(4, 1)), mark);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    req.func      = 1'($urandom_range(1));
                    req.data_byte = 8'($urandom_range(255));
                    req.first     = 1'($urandom_range(1));
                    req.last      = 1'($urandom_range(1));
                    drive_request(req);
                end
            end
            frames++;
        end

        // Wait for the last owed results, then let the clock run on so that any
        // stray extra result would still be caught.
        drain_results();
        repeat (4) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/cpfc_pkg.sv
hw/rtl/cpfc_if.sv
hw/rtl/cpfc_engine.sv
hw/rtl/cpfc_emitter.sv
hw/rtl/crc16_packet_framer_checker.sv
tb/sv/testbench.sv
